// File: design/rthd_pkg.sv
// Package: shared types and constants for the RTP H.264 depacketizer
`timescale 1ns / 1ps
package rthd_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [7:0] VPT_RESET    = 8'd96;
    localparam logic [4:0] NAL_FU_A     = 5'h1C;
    localparam logic [4:0] NAL_IDR      = 5'd5;
    localparam logic [4:0] NAL_SEI      = 5'd6;
    localparam logic [4:0] NAL_SPS      = 5'd7;
    localparam logic [4:0] NAL_PPS      = 5'd8;
    localparam logic [3:0] HDR_LEN      = 4'd12;
    localparam logic [3:0] EXT_HDR_LEN  = 4'd4;

    localparam int         POS_W        = 3;
    localparam logic [POS_W-1:0] POS_SC_ONE = 3'd3;
    localparam logic [POS_W-1:0] POS_SC_NAL = 3'd4;

    typedef struct packed {
        logic [7:0]  data;
        logic        start;
        logic        last;
        logic        key;
        logic [15:0] seq;
    } t_cmd;

endpackage

// File: design/rthd_in_if.sv
// Interface: input byte channel
`timescale 1ns / 1ps
interface rthd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: design/rthd_out_if.sv
// Interface: Annex-B output byte channel
`timescale 1ns / 1ps
interface rthd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        packet_end;
    logic        key_frame;
    logic [15:0] packet_seq;

    modport source (output valid, output out_byte, output run_last, output packet_end,
                    output key_frame, output packet_seq, input ready);
    modport sink   (input valid, input out_byte, input run_last, input packet_end,
                    input key_frame, input packet_seq, output ready);
endinterface

// File: design/rtp_h264_depacketizer.sv
// Top level: RTP to Annex-B H.264 depacketizer
// The block takes one packet byte per cycle whenever its four-entry command queue has room,
// and sends one Annex-B byte per cycle from a registered output while the sink is ready. A
// byte that opens a NAL unit (a single NAL packet, or an FU-A header while no NAL is open)
// yields five output bytes, other payload bytes one; FU-A indicators, FU-A headers of an open
// NAL, header and dropped bytes yield none. Plain payload can enter at one byte per cycle; a
// NAL start takes five bytes of the single-byte output port, which sets the sustained rate.
`timescale 1ns / 1ps
module rtp_h264_depacketizer
    import rthd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_data,
    rthd_in_if.sink    i_in,
    rthd_out_if.source o_out
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_cmd push_cmd;
    t_cmd head_cmd;

    rthd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (push_cmd)
    );

    rthd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    rthd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

// File: design/rthd_front.sv
// Front end: RTP header parser and payload classifier
`timescale 1ns / 1ps
module rthd_front
    import rthd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_data,
    rthd_in_if.sink    i_in,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CSRC,
        PH_EXTHDR,
        PH_EXTSKIP,
        PH_PAYLOAD,
        PH_DROP
    } t_phase;

    t_phase      r_phase,    n_phase;
    logic [3:0]  r_hdr_idx,  n_hdr_idx;
    logic [17:0] r_skip,     n_skip;
    logic [3:0]  r_csrc,     n_csrc;
    logic        r_has_ext,  n_has_ext;
    logic        r_marker,   n_marker;
    logic        r_type_ok,  n_type_ok;
    logic [15:0] r_cur_seq,  n_cur_seq;
    logic [15:0] r_prev_seq, n_prev_seq;
    logic        r_nal,      n_nal;
    logic [1:0]  r_pay_idx,  n_pay_idx;
    logic [7:0]  r_first,    n_first;
    logic        r_key,      n_key;
    logic [6:0]  r_vpt;

    logic        acc;
    logic [7:0]  b;
    logic [15:0] seq_diff;
    logic        emit;
    logic        emit_start;
    logic [7:0]  emit_byte;

    assign i_in.ready = !i_q_full;
    assign acc        = i_in.valid && i_in.ready;
    assign b          = i_in.in_byte;
    assign seq_diff   = r_cur_seq - r_prev_seq;

    always_comb begin
        n_phase    = r_phase;
        n_hdr_idx  = r_hdr_idx;
        n_skip     = r_skip;
        n_csrc     = r_csrc;
        n_has_ext  = r_has_ext;
        n_marker   = r_marker;
        n_type_ok  = r_type_ok;
        n_cur_seq  = r_cur_seq;
        n_prev_seq = r_prev_seq;
        n_nal      = r_nal;
        n_pay_idx  = r_pay_idx;
        n_first    = r_first;
        n_key      = r_key;
        emit       = 1'b0;
        emit_start = 1'b0;
        emit_byte  = b;
        if (acc) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_hdr_idx == 4'd0) begin
                        n_csrc    = b[3:0];
                        n_has_ext = b[4];
                    end else if (r_hdr_idx == 4'd1) begin
                        n_marker  = b[7];
                        n_type_ok = (b[6:0] == r_vpt);
                    end else if (r_hdr_idx == 4'd2) begin
                        n_cur_seq = {b, 8'h00};
                    end else if (r_hdr_idx == 4'd3) begin
                        n_cur_seq = {r_cur_seq[15:8], b};
                    end
                    n_hdr_idx = r_hdr_idx + 4'd1;
                    if (n_hdr_idx == 4'd2 && !n_type_ok) begin
                        n_phase = PH_DROP;
                    end else if (n_hdr_idx >= HDR_LEN) begin
                        n_hdr_idx = 4'd0;
                        if (n_csrc != 4'd0) begin
                            n_skip  = {12'd0, n_csrc, 2'b00};
                            n_phase = PH_CSRC;
                        end else if (n_has_ext) begin
                            n_phase = PH_EXTHDR;
                        end else begin
                            n_phase   = PH_PAYLOAD;
                            n_pay_idx = 2'd0;
                        end
                    end
                end
                PH_CSRC: begin
                    n_skip = r_skip - 18'd1;
                    if (n_skip == 18'd0) begin
                        if (r_has_ext) begin
                            n_phase   = PH_EXTHDR;
                            n_hdr_idx = 4'd0;
                        end else begin
                            n_phase   = PH_PAYLOAD;
                            n_pay_idx = 2'd0;
                        end
                    end
                end
                PH_EXTHDR: begin
                    if (r_hdr_idx == 4'd2) begin
                        n_skip = {2'b00, b, 8'h00};
                    end else if (r_hdr_idx == 4'd3) begin
                        n_skip = {r_skip[15:8], b, 2'b00};
                    end
                    n_hdr_idx = r_hdr_idx + 4'd1;
                    if (n_hdr_idx >= EXT_HDR_LEN) begin
                        n_hdr_idx = 4'd0;
                        if (n_skip == 18'd0) begin
                            n_phase   = PH_PAYLOAD;
                            n_pay_idx = 2'd0;
                        end else begin
                            n_phase = PH_EXTSKIP;
                        end
                    end
                end
                PH_EXTSKIP: begin
                    n_skip = r_skip - 18'd1;
                    if (n_skip == 18'd0) begin
                        n_phase   = PH_PAYLOAD;
                        n_pay_idx = 2'd0;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_pay_idx == 2'd0) begin
                        if (seq_diff > 16'd1) begin
                            n_nal = 1'b0;
                        end
                        n_prev_seq = r_cur_seq;
                        n_first    = b;
                        if (b[4:0] != NAL_FU_A) begin
                            n_key      = (b[4:0] == NAL_IDR) || (b[4:0] == NAL_SEI) ||
                                         (b[4:0] == NAL_SPS) || (b[4:0] == NAL_PPS);
                            n_nal      = 1'b0;
                            emit       = 1'b1;
                            emit_start = 1'b1;
                        end
                        n_pay_idx = 2'd1;
                    end else if (r_pay_idx == 2'd1) begin
                        if (r_first[4:0] == NAL_FU_A) begin
                            n_key = (b[4:0] == NAL_IDR);
                            if (!r_nal) begin
                                emit       = 1'b1;
                                emit_start = 1'b1;
                                emit_byte  = {r_first[7:5], b[4:0]};
                                n_nal      = 1'b1;
                            end
                        end else begin
                            emit = 1'b1;
                        end
                        n_pay_idx = 2'd2;
                    end else begin
                        emit = 1'b1;
                    end
                end
                PH_DROP: begin
                end
                default: begin
                end
            endcase
            if (i_in.in_last) begin
                if (n_phase == PH_PAYLOAD && n_pay_idx != 2'd0 &&
                    n_first[4:0] == NAL_FU_A && n_marker) begin
                    n_nal = 1'b0;
                end
                n_phase   = PH_HEADER;
                n_hdr_idx = 4'd0;
                n_skip    = 18'd0;
                n_pay_idx = 2'd0;
            end
        end
    end

    assign o_push      = acc && emit;
    assign o_cmd.data  = emit_byte;
    assign o_cmd.start = emit_start;
    assign o_cmd.last  = i_in.in_last;
    assign o_cmd.key   = n_key;
    assign o_cmd.seq   = n_cur_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hdr_idx  <= 4'd0;
            r_skip     <= 18'd0;
            r_csrc     <= 4'd0;
            r_has_ext  <= 1'b0;
            r_marker   <= 1'b0;
            r_type_ok  <= 1'b0;
            r_cur_seq  <= 16'd0;
            r_prev_seq <= 16'd0;
            r_nal      <= 1'b0;
            r_pay_idx  <= 2'd0;
            r_first    <= 8'd0;
            r_key      <= 1'b0;
            r_vpt      <= VPT_RESET[6:0];
        end else begin
            r_phase    <= n_phase;
            r_hdr_idx  <= n_hdr_idx;
            r_skip     <= n_skip;
            r_csrc     <= n_csrc;
            r_has_ext  <= n_has_ext;
            r_marker   <= n_marker;
            r_type_ok  <= n_type_ok;
            r_cur_seq  <= n_cur_seq;
            r_prev_seq <= n_prev_seq;
            r_nal      <= n_nal;
            r_pay_idx  <= n_pay_idx;
            r_first    <= n_first;
            r_key      <= n_key;
            if (i_cfg_we) begin
                r_vpt <= i_cfg_data;
            end
        end
    end

endmodule

// File: design/rthd_queue.sv
// Command queue between the parser and the output expander
`timescale 1ns / 1ps
module rthd_queue
    import rthd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QCW-1:0] r_cnt;
    logic           push;
    logic           pop;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
    end

endmodule

// File: design/rthd_back.sv
// Back end: expands queued commands into Annex-B output bytes
`timescale 1ns / 1ps
module rthd_back
    import rthd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    rthd_out_if.source o_out
);

    logic             r_valid;
    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_byte;
    logic             r_run_last;
    logic             r_pkt_end;
    logic             r_key;
    logic [15:0]      r_seq;

    logic             load;
    logic             cmd_done;
    logic [7:0]       n_byte;

    assign load     = (!r_valid || o_out.ready) && i_q_valid;
    assign cmd_done = !i_cmd.start || (r_pos == POS_SC_NAL);
    assign o_pop    = load && cmd_done;

    always_comb begin
        if (!i_cmd.start || r_pos == POS_SC_NAL) begin
            n_byte = i_cmd.data;
        end else if (r_pos == POS_SC_ONE) begin
            n_byte = 8'h01;
        end else begin
            n_byte = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_pos   <= cmd_done ? '0 : r_pos + POS_W'(1);
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte     <= n_byte;
            r_run_last <= cmd_done;
            r_pkt_end  <= cmd_done && i_cmd.last;
            r_key      <= i_cmd.key;
            r_seq      <= i_cmd.seq;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_byte;
    assign o_out.run_last   = r_run_last;
    assign o_out.packet_end = r_pkt_end;
    assign o_out.key_frame  = r_key;
    assign o_out.packet_seq = r_seq;

endmodule

// File: dv/rtp_h264_depacketizer_tb.sv
// Testbench: RTP packet byte stimulus with a cycle-free Annex-B predictor and output check
`timescale 1ns / 1ps
module rtp_h264_depacketizer_tb;
    import rthd_pkg::*;

    localparam int LONG_HOLD   = 300;
    localparam int IDLE_LIMIT  = 2000;
    localparam int SETTLE      = 16;
    localparam int MAX_REPORTS = 40;

    typedef enum logic [2:0] {
        PH_HEADER, PH_CSRC, PH_EXT_HDR, PH_EXT_SKIP, PH_PAYLOAD, PH_DROP
    } t_rtp_phase;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        int unsigned gap;
    } t_rtp_byte;

    typedef struct {
        logic [7:0]  data;
        logic        run_last;
        logic        pkt_end;
        logic        key;
        logic [15:0] seq;
    } t_annexb_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [6:0] i_cfg_data;

    rthd_in_if  in_ch ();
    rthd_out_if out_ch ();

    rtp_h264_depacketizer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_rtp_byte    rtp_pending_q[$];
    t_annexb_byte annexb_expected_q[$];
    t_annexb_byte annexb_step_q[$];
    logic [7:0]   nal_q[$];

    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int          hold_reqs = 0;
    int          holds_served = 0;
    int unsigned n_queued = 0;
    int unsigned n_pkts = 0;
    int unsigned n_in = 0;
    int unsigned n_out = 0;
    int unsigned n_cfg = 0;
    int unsigned n_err = 0;
    logic [15:0] seq_next;

    // depacketizer state as seen by the predictor
    logic [6:0]  pt_sel;
    t_rtp_phase  phase;
    logic [3:0]  hdr_idx;
    logic [17:0] skip_cnt;
    logic [3:0]  csrc_cnt;
    logic        ext_flag;
    logic        marker;
    logic        pt_match;
    logic [15:0] pkt_seq;
    logic [15:0] last_seq;
    logic        nal_open;
    logic [1:0]  pay_idx;
    logic [7:0]  lead_byte;
    logic        key_nal;

    function automatic int unsigned idle_len(input int unsigned pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic clear_state();
        pt_sel    = VPT_RESET[6:0];
        phase     = PH_HEADER;
        hdr_idx   = '0;
        skip_cnt  = '0;
        csrc_cnt  = '0;
        ext_flag  = 1'b0;
        marker    = 1'b0;
        pt_match  = 1'b0;
        pkt_seq   = '0;
        last_seq  = '0;
        nal_open  = 1'b0;
        pay_idx   = '0;
        lead_byte = '0;
        key_nal   = 1'b0;
    endtask

    task automatic emit_byte(input logic [7:0] b);
        t_annexb_byte r;
        r.data     = b;
        r.run_last = 1'b0;
        r.pkt_end  = 1'b0;
        r.key      = key_nal;
        r.seq      = pkt_seq;
        annexb_step_q.push_back(r);
    endtask

    task automatic emit_start_code(input logic [7:0] nal_hdr);
        emit_byte(8'h00);
        emit_byte(8'h00);
        emit_byte(8'h00);
        emit_byte(8'h01);
        emit_byte(nal_hdr);
    endtask

    task automatic open_payload();
        phase   = PH_PAYLOAD;
        pay_idx = '0;
    endtask

    task automatic leave_csrc();
        if (ext_flag) begin
            phase   = PH_EXT_HDR;
            hdr_idx = '0;
        end else begin
            open_payload();
        end
    endtask

    task automatic depacketize_byte(input logic [7:0] b, input logic last);
        logic [15:0] seq_step;
        logic [4:0]  t;
        annexb_step_q.delete();
        case (phase)
            PH_HEADER: begin
                case (hdr_idx)
                    4'd0: begin
                        csrc_cnt = b[3:0];
                        ext_flag = b[4];
                    end
                    4'd1: begin
                        marker   = b[7];
                        pt_match = (b[6:0] == pt_sel);
                    end
                    4'd2: pkt_seq = {b, 8'h00};
                    4'd3: pkt_seq[7:0] = b;
                    default: ;
                endcase
                hdr_idx = hdr_idx + 4'd1;
                if (hdr_idx == 4'd2 && !pt_match) begin
                    phase = PH_DROP;
                end else if (hdr_idx >= HDR_LEN) begin
                    hdr_idx = '0;
                    if (csrc_cnt != 0) begin
                        skip_cnt = {12'd0, csrc_cnt, 2'b00};
                        phase    = PH_CSRC;
                    end else begin
                        leave_csrc();
                    end
                end
            end
            PH_CSRC: begin
                skip_cnt = skip_cnt - 18'd1;
                if (skip_cnt == 0)
                    leave_csrc();
            end
            PH_EXT_HDR: begin
                if (hdr_idx == 4'd2)
                    skip_cnt = {2'b00, b, 8'h00};
                else if (hdr_idx == 4'd3)
                    skip_cnt = {skip_cnt[15:8], b, 2'b00};
                hdr_idx = hdr_idx + 4'd1;
                if (hdr_idx >= EXT_HDR_LEN) begin
                    hdr_idx = '0;
                    if (skip_cnt == 0)
                        open_payload();
                    else
                        phase = PH_EXT_SKIP;
                end
            end
            PH_EXT_SKIP: begin
                skip_cnt = skip_cnt - 18'd1;
                if (skip_cnt == 0)
                    open_payload();
            end
            PH_PAYLOAD: begin
                if (pay_idx == 2'd0) begin
                    seq_step = pkt_seq - last_seq;
                    if (seq_step > 16'd1)
                        nal_open = 1'b0;
                    last_seq  = pkt_seq;
                    lead_byte = b;
                    t = b[4:0];
                    if (t != NAL_FU_A) begin
                        key_nal  = (t == NAL_IDR) || (t == NAL_SEI) ||
                                   (t == NAL_SPS) || (t == NAL_PPS);
                        nal_open = 1'b0;
                        emit_start_code(b);
                    end
                    pay_idx = 2'd1;
                end else if (pay_idx == 2'd1) begin
                    if (lead_byte[4:0] == NAL_FU_A) begin
                        key_nal = (b[4:0] == NAL_IDR);
                        if (!nal_open) begin
                            emit_start_code({lead_byte[7:5], b[4:0]});
                            nal_open = 1'b1;
                        end
                    end else begin
                        emit_byte(b);
                    end
                    pay_idx = 2'd2;
                end else begin
                    emit_byte(b);
                end
            end
            default: ;
        endcase

        if (last) begin
            if (phase == PH_PAYLOAD && pay_idx >= 2'd1 &&
                lead_byte[4:0] == NAL_FU_A && marker)
                nal_open = 1'b0;
            phase    = PH_HEADER;
            hdr_idx  = '0;
            skip_cnt = '0;
            pay_idx  = '0;
        end

        if (annexb_step_q.size() > 0) begin
            annexb_step_q[annexb_step_q.size() - 1].run_last = 1'b1;
            annexb_step_q[annexb_step_q.size() - 1].pkt_end  = last;
        end
        foreach (annexb_step_q[i])
            annexb_expected_q.push_back(annexb_step_q[i]);
    endtask

    // packet assembly: header, CSRC list, extension, then nal_q; cut trims to that many bytes
    task automatic queue_packet(input logic [6:0] pt, input logic mark, input logic [15:0] seq,
                                input int unsigned n_csrc, input logic has_ext,
                                input logic [15:0] ext_words, input int unsigned cut);
        logic [7:0]  raw[$];
        int unsigned lim;
        t_rtp_byte   pb;
        lim = (cut == 0) ? 32'hFFFF_FFFF : cut;
        raw.push_back({3'($urandom_range(0, 7)), has_ext, 4'(n_csrc)});
        raw.push_back({mark, pt});
        raw.push_back(seq[15:8]);
        raw.push_back(seq[7:0]);
        for (int i = 0; i < 8 + 4 * n_csrc; i++)
            raw.push_back(8'($urandom_range(0, 255)));
        if (has_ext) begin
            raw.push_back(8'($urandom_range(0, 255)));
            raw.push_back(8'($urandom_range(0, 255)));
            raw.push_back(ext_words[15:8]);
            raw.push_back(ext_words[7:0]);
            for (int i = 0; i < 4 * ext_words && raw.size() < lim; i++)
                raw.push_back(8'($urandom_range(0, 255)));
        end
        foreach (nal_q[i])
            raw.push_back(nal_q[i]);
        while (raw.size() > lim)
            void'(raw.pop_back());
        for (int i = 0; i < raw.size(); i++) begin
            pb.data = raw[i];
            pb.last = (i == raw.size() - 1);
            pb.gap  = idle_len(src_idle_pct);
            rtp_pending_q.push_back(pb);
        end
        n_queued += raw.size();
        n_pkts++;
    endtask

    task automatic queue_noise();
        int unsigned n;
        t_rtp_byte   pb;
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++) begin
            pb.data = 8'($urandom_range(0, 255));
            pb.last = (i == n - 1);
            pb.gap  = idle_len(src_idle_pct);
            rtp_pending_q.push_back(pb);
        end
        n_queued += n;
    endtask

    task automatic fill_single(input logic [4:0] t, input int unsigned n_extra);
        nal_q.delete();
        nal_q.push_back({3'($urandom_range(0, 7)), t});
        repeat (n_extra)
            nal_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic fill_fu(input logic [1:0] se, input logic [4:0] t, input int unsigned n_data);
        nal_q.delete();
        nal_q.push_back({3'($urandom_range(0, 7)), NAL_FU_A});
        nal_q.push_back({se, 1'($urandom_range(0, 1)), t});
        repeat (n_data)
            nal_q.push_back(8'($urandom_range(0, 255)));
    endtask

    function automatic logic [4:0] pick_nal_type();
        int unsigned r;
        logic [4:0]  t;
        r = $urandom_range(0, 99);
        if (r < 40) return 5'd1;
        if (r < 60) return NAL_IDR;
        if (r < 67) return NAL_SEI;
        if (r < 74) return NAL_SPS;
        if (r < 80) return NAL_PPS;
        t = NAL_FU_A;
        while (t == NAL_FU_A)
            t = 5'($urandom_range(0, 31));
        return t;
    endfunction

    // mostly in order, with the odd jump, repeat or step back
    task automatic advance_seq();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6)
            seq_next = seq_next + 16'($urandom_range(2, 400));
        else if (r < 10)
            seq_next = seq_next;
        else if (r < 12)
            seq_next = seq_next - 16'd1;
        else
            seq_next = seq_next + 16'd1;
    endtask

    task automatic directed_packets();
        logic [6:0] pt;
        pt = pt_sel;
        fill_single(NAL_SPS, 4);      queue_packet(pt, 1'b0, 16'd1, 0, 1'b0, 16'd0, 0);
        fill_single(NAL_PPS, 2);      queue_packet(pt, 1'b0, 16'd2, 0, 1'b0, 16'd0, 0);
        fill_single(NAL_SEI, 1);      queue_packet(pt, 1'b0, 16'd3, 0, 1'b0, 16'd0, 0);
        fill_fu(2'b10, NAL_IDR, 3);   queue_packet(pt, 1'b0, 16'd4, 0, 1'b0, 16'd0, 0);
        fill_fu(2'b00, NAL_IDR, 2);   queue_packet(pt, 1'b0, 16'd5, 0, 1'b0, 16'd0, 0);
        fill_fu(2'b01, NAL_IDR, 1);   queue_packet(pt, 1'b1, 16'd6, 0, 1'b0, 16'd0, 0);
        fill_fu(2'b10, 5'd1, 2);      queue_packet(pt, 1'b0, 16'd7, 0, 1'b0, 16'd0, 0);
        // gap in sequence: the continuation reopens with a start code
        fill_fu(2'b00, 5'd1, 2);      queue_packet(pt, 1'b0, 16'd9, 0, 1'b0, 16'd0, 0);
        // repeated sequence number keeps the NAL open
        fill_fu(2'b00, 5'd1, 1);      queue_packet(pt, 1'b0, 16'd9, 0, 1'b0, 16'd0, 0);
        fill_single(NAL_IDR, 3);      queue_packet(pt ^ 7'h01, 1'b1, 16'd10, 0, 1'b0, 16'd0, 0);
        // ends inside the fixed header
        fill_single(5'd1, 2);         queue_packet(pt, 1'b0, 16'd11, 0, 1'b0, 16'd0, 7);
        // indicator only, marker set; the sequence gap from 9 has already closed the NAL
        fill_fu(2'b00, 5'd1, 2);      queue_packet(pt, 1'b1, 16'd12, 0, 1'b0, 16'd0, 13);
        fill_fu(2'b00, 5'd1, 1);      queue_packet(pt, 1'b0, 16'd13, 0, 1'b0, 16'd0, 0);
        // cut after the FU header with the NAL open: nothing leaves for this packet
        fill_fu(2'b00, 5'd1, 3);      queue_packet(pt, 1'b0, 16'd14, 0, 1'b0, 16'd0, 14);
        fill_single(NAL_IDR, 2);      queue_packet(pt, 1'b0, 16'd15, 15, 1'b1, 16'd2, 0);
        fill_single(5'd1, 1);         queue_packet(pt, 1'b0, 16'd16, 0, 1'b1, 16'hFFFF, 24);
        nal_q.delete();
        nal_q.push_back(8'h00);       queue_packet(pt, 1'b1, 16'd17, 0, 1'b0, 16'd0, 0);
        nal_q.delete();
        nal_q.push_back(8'hFF);       queue_packet(pt, 1'b0, 16'd18, 0, 1'b0, 16'd0, 0);
        fill_fu(2'b10, 5'd1, 1);      queue_packet(pt, 1'b0, 16'hFFFF, 0, 1'b0, 16'd0, 0);
        fill_fu(2'b01, 5'd1, 1);      queue_packet(pt, 1'b1, 16'h0000, 0, 1'b0, 16'd0, 0);
        seq_next = 16'h0000;
    endtask

    task automatic random_traffic(input int unsigned n_bytes);
        int unsigned goal, r, k, n_csrc, hlen, cut;
        logic        ext, mark;
        logic [15:0] words;
        logic [4:0]  t;
        goal = n_queued + n_bytes;
        while (n_queued < goal) begin
            r      = $urandom_range(0, 99);
            n_csrc = ($urandom_range(0, 99) < 12) ? $urandom_range(1, 15) : 0;
            ext    = ($urandom_range(0, 99) < 12);
            words  = 16'($urandom_range(0, 3));
            hlen   = 12 + 4 * n_csrc + (ext ? 4 + 4 * words : 0);
            if (r < 45) begin
                t = pick_nal_type();
                k = $urandom_range(1, 4);
                for (int j = 0; j < k; j++) begin
                    advance_seq();
                    fill_fu({j == 0, j == k - 1}, t, $urandom_range(1, 8));
                    mark = (j == k - 1) ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 19) == 0);
                    cut  = ($urandom_range(0, 19) == 0) ? hlen + $urandom_range(1, nal_q.size()) : 0;
                    queue_packet(pt_sel, mark, seq_next, n_csrc, ext, words, cut);
                end
            end else if (r < 70) begin
                advance_seq();
                t = NAL_FU_A;
                while (t == NAL_FU_A)
                    t = pick_nal_type();
                fill_single(t, $urandom_range(0, 10));
                queue_packet(pt_sel, 1'($urandom_range(0, 1)), seq_next, n_csrc, ext, words, 0);
            end else if (r < 80) begin
                fill_single(pick_nal_type(), $urandom_range(0, 6));
                queue_packet(pt_sel + 7'($urandom_range(1, 127)), 1'($urandom_range(0, 1)),
                             16'($urandom_range(0, 65535)), n_csrc, ext, words, 0);
            end else if (r < 90) begin
                advance_seq();
                fill_fu(2'($urandom_range(0, 3)), pick_nal_type(), 2);
                queue_packet(pt_sel, 1'($urandom_range(0, 1)), seq_next, n_csrc, ext, words,
                             $urandom_range(1, hlen + 2));
            end else begin
                queue_noise();
            end
        end
    endtask

    task automatic write_pt_sel(input logic [6:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        pt_sel = v;
        n_cfg++;
    endtask

    task automatic wait_drained();
        while (rtp_pending_q.size() != 0 || in_ch.valid || annexb_expected_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want) begin
            n_err++;
            if (n_err <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // source: hold each byte until transferred, then idle for its gap
    logic        in_fire;
    t_rtp_byte   drv_item;
    int unsigned drv_gap = 0;

    always @(posedge i_clk) begin
        in_fire <= in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            depacketize_byte(in_ch.in_byte, in_ch.in_last);
            n_in++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_fire) begin
            if (drv_gap > 0) begin
                in_ch.valid <= 1'b0;
                drv_gap--;
            end else if (rtp_pending_q.size() > 0) begin
                drv_item = rtp_pending_q.pop_front();
                in_ch.in_byte <= drv_item.data;
                in_ch.in_last <= drv_item.last;
                in_ch.valid   <= 1'b1;
                drv_gap = drv_item.gap;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // sink: random stalls, plus a long hold on request
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end else if (holds_served != hold_reqs) begin
            holds_served++;
            hold_left = LONG_HOLD - 1;
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            stall_left = idle_len(snk_idle_pct);
            out_ch.ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    t_annexb_byte mon_want;

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_out++;
            if (annexb_expected_q.size() == 0) begin
                n_err++;
                if (n_err <= MAX_REPORTS)
                    $display("%0t: unexpected output, expected none, got byte %h seq %h",
                             $time, out_ch.out_byte, out_ch.packet_seq);
            end else begin
                mon_want = annexb_expected_q.pop_front();
                check_field("out_byte", 16'(mon_want.data), 16'(out_ch.out_byte));
                check_field("run_last", 16'(mon_want.run_last), 16'(out_ch.run_last));
                check_field("packet_end", 16'(mon_want.pkt_end), 16'(out_ch.packet_end));
                check_field("key_frame", 16'(mon_want.key), 16'(out_ch.key_frame));
                check_field("packet_seq", mon_want.seq, out_ch.packet_seq);
            end
        end
    end

    int unsigned stuck_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            !(rtp_pending_q.size() > 0 || in_ch.valid || annexb_expected_q.size() > 0)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, stuck_cycles, annexb_expected_q.size());
                $display("rtp_h264_depacketizer_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        in_ch.valid    = 1'b0;
        in_ch.in_byte  = '0;
        in_ch.in_last  = 1'b0;
        out_ch.ready   = 1'b0;
        seq_next       = '0;
        clear_state();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_packets();
        wait_drained();

        src_idle_pct = 30;
        snk_idle_pct = 30;
        random_traffic(15);
        wait_drained();
        random_traffic(15);
        wait_drained();

        write_pt_sel(7'd0);
        src_idle_pct = 5;
        snk_idle_pct = 20;
        hold_reqs++;
        random_traffic(25);
        wait_drained();

        write_pt_sel(7'd127);
        seq_next = 16'hFFF0;
        src_idle_pct = 50;
        snk_idle_pct = 50;
        random_traffic(20);
        wait_drained();

        write_pt_sel(7'($urandom_range(1, 126)));
        src_idle_pct = 20;
        snk_idle_pct = 5;
        random_traffic(20);
        wait_drained();

        write_pt_sel(VPT_RESET[6:0]);
        src_idle_pct = 10;
        snk_idle_pct = 40;
        random_traffic(10);
        wait_drained();

        $display("covered %0d packets, %0d bytes in, %0d Annex-B bytes checked",
                 n_pkts, n_in, n_out);
        $display("payload type set %0d times incl. 0 and 127, one long output hold", n_cfg);
        if (n_err == 0)
            $display("rtp_h264_depacketizer_tb: done, clean");
        else
            $display("rtp_h264_depacketizer_tb: done, errors");
        $finish;
    end

endmodule

// File: sim.f
design/rthd_pkg.sv
design/rthd_in_if.sv
design/rthd_out_if.sv
design/rthd_front.sv
design/rthd_queue.sv
design/rthd_back.sv
design/rtp_h264_depacketizer.sv
dv/rtp_h264_depacketizer_tb.sv
